>>> rtl/pswi_pkg.sv
`default_nettype none
package pswi_pkg;

	localparam int WindowDefault = 64;
	localparam int RegCount = 7;
	localparam int RegIdxWidth = 3;

	localparam logic [RegIdxWidth-1:0] RegGainP = 3'd0;
	localparam logic [RegIdxWidth-1:0] RegGainI = 3'd1;
	localparam logic [RegIdxWidth-1:0] RegGainD = 3'd2;
	localparam logic [RegIdxWidth-1:0] RegSamplePeriod = 3'd3;
	localparam logic [RegIdxWidth-1:0] RegIntegLimit = 3'd4;
	localparam logic [RegIdxWidth-1:0] RegOutputLimit = 3'd5;
	localparam logic [RegIdxWidth-1:0] RegFeedForward = 3'd6;

	localparam logic [30:0] SamplePeriodReset = 31'd65536;
	localparam logic [30:0] IntegLimitReset = 31'h7FFF_FFFF;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PMUL,
		ST_IMUL1,
		ST_IMUL2,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_DMUL,
		ST_RING_RD,
		ST_RING_UPD,
		ST_SUM,
		ST_OUT
	} state_t;

	// Divider handshake.
	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// Saturate a 64-bit signed value to 32 bits.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	// Q16.16 product scaling: floor shift by 16, then saturation.
	function automatic logic signed [31:0] qscale(input logic signed [63:0] prod);
		logic signed [63:0] s;
		s = prod >>> 16;
		return sat32(s);
	endfunction

endpackage
`default_nettype wire

>>> rtl/pswi_ram.sv
`default_nettype none
module pswi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/pswi_div.sv
`default_nettype none
module pswi_div (
	input  wire                    clk,
	input  wire                    arst_n,
	input  pswi_pkg::div_ctrl_t    ctrl,
	input  wire signed [48:0]      dividend,
	input  wire [30:0]             divisor,
	output pswi_pkg::div_stat_t    stat,
	output logic signed [31:0]     quotient
);

	logic [48:0] rem_q;
	logic [48:0] quo_q;
	logic [30:0] dvs_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [49:0] trial;
	logic [48:0] shifted;
	logic signed [49:0] signed_q;

	// Restoring division of the magnitude, one quotient bit per cycle.
	assign shifted = {rem_q[47:0], quo_q[48]};
	assign trial = {1'b0, shifted} - {19'd0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd49;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			quo_q <= dividend[48] ? 49'(-dividend) : 49'(dividend);
			neg_q <= dividend[48];
			dvs_q <= (divisor == 31'd0) ? 31'd1 : divisor;
		end else if (busy_q) begin
			if (!trial[49]) begin
				rem_q <= trial[48:0];
				quo_q <= {quo_q[47:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[47:0], 1'b0};
			end
		end
	end

	// Sign fix and saturation; quotient magnitude stays below 2^49.
	always_comb begin
		signed_q = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		quotient = pswi_pkg::sat32(64'(signed_q));
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

>>> rtl/pid_sliding_window_integral.sv
`default_nettype none
// Channel  | handshake                     | payload
// in       | in_valid / in_ready           | req_type, error_in
// out      | out_valid / out_ready         | drive, integral_term
// cfg      | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// An update word is held mainly by the 49-step bit-serial divider for the derivative;
// a clear word skips the arithmetic and goes straight to the output state.
// One word is in work at a time.
// The result sits in an output register; the next word is taken while it waits.
// A new result waits in the output state while the previous one is not yet taken.
// Reset clears FSM, config, integral, out_valid; the ring needs no clearing pass.
module pid_sliding_window_integral #(
	parameter int WINDOW = pswi_pkg::WindowDefault
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 req_type,
	input  wire signed [31:0]   error_in,
	output logic                out_valid,
	input  wire                 out_ready,
	output logic signed [31:0]  drive,
	output logic signed [31:0]  integral_term,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [pswi_pkg::RegIdxWidth-1:0] cfg_index,
	input  wire [31:0]          cfg_data
);

	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [AW-1:0] LastPos = AW'(WINDOW - 1);

	pswi_pkg::state_t state_q, state_d;

	logic signed [31:0] gain_p_q, gain_i_q, gain_d_q, ff_q;
	logic [30:0] period_q, ilim_q, olim_q;

	logic signed [31:0] last_err_q, err_q;
	logic clr_q;
	logic signed [47:0] isum_q;
	logic [AW-1:0] pos_q;
	logic full_q;

	logic signed [63:0] prod;
	logic signed [31:0] mul_a, mul_b;
	logic signed [31:0] p_q, inc_q, tmp_q, d_q, iterm_q, deriv_q;
	logic signed [47:0] isum_new;
	logic [AW-1:0] pos_next;
	logic wrap;

	logic ram_we;
	logic [31:0] ram_rdata;
	pswi_pkg::div_ctrl_t div_ctrl;
	pswi_pkg::div_stat_t div_stat;
	logic signed [31:0] div_quo;
	logic signed [48:0] div_num;

	logic out_free;
	logic in_acc;
	logic signed [35:0] total;
	logic signed [35:0] clamped;
	logic signed [35:0] olim_s;
	logic signed [48:0] ilim_s;

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == pswi_pkg::ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q <= '0;
			gain_i_q <= '0;
			gain_d_q <= '0;
			period_q <= pswi_pkg::SamplePeriodReset;
			ilim_q <= pswi_pkg::IntegLimitReset;
			olim_q <= '0;
			ff_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pswi_pkg::RegGainP: gain_p_q <= cfg_data;
				pswi_pkg::RegGainI: gain_i_q <= cfg_data;
				pswi_pkg::RegGainD: gain_d_q <= cfg_data;
				pswi_pkg::RegSamplePeriod: period_q <= cfg_data[30:0];
				pswi_pkg::RegIntegLimit: ilim_q <= cfg_data[30:0];
				pswi_pkg::RegOutputLimit: olim_q <= cfg_data[30:0];
				pswi_pkg::RegFeedForward: ff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pswi_pkg::ST_IDLE: if (in_valid) begin
				state_d = req_type ? pswi_pkg::ST_OUT : pswi_pkg::ST_PMUL;
			end
			pswi_pkg::ST_PMUL: state_d = pswi_pkg::ST_IMUL1;
			pswi_pkg::ST_IMUL1: state_d = pswi_pkg::ST_IMUL2;
			pswi_pkg::ST_IMUL2: state_d = pswi_pkg::ST_DIV_START;
			pswi_pkg::ST_DIV_START: state_d = pswi_pkg::ST_DIV_WAIT;
			pswi_pkg::ST_DIV_WAIT: if (div_stat.done) state_d = pswi_pkg::ST_DMUL;
			pswi_pkg::ST_DMUL: state_d = pswi_pkg::ST_RING_RD;
			pswi_pkg::ST_RING_RD: state_d = pswi_pkg::ST_RING_UPD;
			pswi_pkg::ST_RING_UPD: state_d = pswi_pkg::ST_SUM;
			pswi_pkg::ST_SUM: state_d = pswi_pkg::ST_OUT;
			pswi_pkg::ST_OUT: if (out_free) state_d = pswi_pkg::ST_IDLE;
			default: state_d = pswi_pkg::ST_IDLE;
		endcase
	end

	// Shared multiplier operand selection, divider start and ring write enable.
	always_comb begin
		mul_a = gain_p_q;
		mul_b = err_q;
		div_ctrl.start = 1'b0;
		ram_we = 1'b0;
		unique case (state_q)
			pswi_pkg::ST_IMUL1: begin
				mul_a = gain_i_q;
				mul_b = err_q;
			end
			pswi_pkg::ST_IMUL2: begin
				mul_a = tmp_q;
				mul_b = $signed({1'b0, period_q});
			end
			pswi_pkg::ST_DIV_START: div_ctrl.start = 1'b1;
			pswi_pkg::ST_DMUL: begin
				mul_a = gain_d_q;
				mul_b = deriv_q;
			end
			pswi_pkg::ST_RING_UPD: ram_we = (gain_i_q != 32'sd0);
			default: ;
		endcase
	end

	assign prod = 64'(mul_a) * 64'(mul_b);
	assign div_num = {49'(err_q) - 49'(last_err_q)} <<< 16;
	assign pos_next = (pos_q == LastPos) ? '0 : pos_q + AW'(1);
	assign wrap = (pos_next == '0) || full_q;
	assign isum_new = isum_q + 48'(inc_q) - (wrap ? 48'($signed(ram_rdata)) : 48'sd0);
	assign ilim_s = 49'(ilim_q);
	assign olim_s = 36'(olim_q);

	pswi_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(div_ctrl),
		.dividend(div_num),
		.divisor(period_q),
		.stat(div_stat),
		.quotient(div_quo)
	);

	// Ring read address is the oldest entry after this write.
	pswi_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_ring (
		.clk(clk),
		.we(ram_we),
		.waddr(pos_q),
		.wdata(inc_q),
		.raddr(pos_next),
		.rdata(ram_rdata)
	);

	// Final sum with optional output clamp.
	always_comb begin
		total = 36'(p_q) + 36'(iterm_q) + 36'(d_q) + 36'(ff_q);
		clamped = total;
		if (olim_q != 31'd0) begin
			if (total > olim_s) clamped = olim_s;
			else if (total < -olim_s) clamped = -olim_s;
		end
	end

	// Datapath and state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pswi_pkg::ST_IDLE;
			last_err_q <= '0;
			isum_q <= '0;
			pos_q <= '0;
			full_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == pswi_pkg::ST_OUT) && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (in_acc) begin
				err_q <= error_in;
				clr_q <= req_type;
				if (req_type) begin
					last_err_q <= '0;
					isum_q <= '0;
					pos_q <= '0;
					full_q <= 1'b0;
					p_q <= '0;
					iterm_q <= '0;
					d_q <= '0;
				end
			end
			unique case (state_q)
				pswi_pkg::ST_PMUL: p_q <= pswi_pkg::qscale(prod);
				pswi_pkg::ST_IMUL1: tmp_q <= pswi_pkg::qscale(prod);
				pswi_pkg::ST_IMUL2: inc_q <= pswi_pkg::qscale(prod);
				pswi_pkg::ST_DIV_WAIT: deriv_q <= div_quo;
				pswi_pkg::ST_DMUL: d_q <= pswi_pkg::qscale(prod);
				pswi_pkg::ST_RING_UPD: begin
					if (gain_i_q == 32'sd0) begin
						iterm_q <= '0;
					end else begin
						isum_q <= isum_new;
						pos_q <= pos_next;
						full_q <= wrap;
						if (49'(isum_new) > ilim_s) iterm_q <= 32'(ilim_q);
						else if (49'(isum_new) < -ilim_s) iterm_q <= -$signed({1'b0, ilim_q});
						else iterm_q <= isum_new[31:0];
					end
				end
				pswi_pkg::ST_SUM: last_err_q <= err_q;
				pswi_pkg::ST_OUT: if (out_free) begin
					drive <= clr_q ? 32'sd0 : pswi_pkg::sat32(64'(clamped));
					integral_term <= iterm_q;
				end
				default: ;
			endcase
		end
	end

	// A result appears only from the output state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == pswi_pkg::ST_OUT)
		else $error("result without output state");

	// The divider is never restarted while busy.
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctrl.start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	// The integral sum stays within the window bound.
	a_isum: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pswi_pkg::ST_IDLE) |-> (isum_q[47] == isum_q[46] || WINDOW > 32768))
		else $error("integral sum out of range");

endmodule
`default_nettype wire
